// ===== design/fdms_pkg.sv =====
// Shared types and constants for the frame difference motion score block.
// Used by the front, job queue, back and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdms_pkg;

  // Frame store geometry
  localparam int MAX_FRAME_PIXELS = 32768;
  localparam int CNT_W            = 16;
  localparam int ADDR_W           = $clog2(MAX_FRAME_PIXELS);
  localparam int MEM_DEPTH        = 2 * (1 << ADDR_W);

  // Arithmetic widths: sum of absolute differences and length*255
  localparam int PIX_W   = 8;
  localparam int PIX_MAX = 255;
  localparam int SUM_W   = $clog2(PIX_MAX * MAX_FRAME_PIXELS + 1);
  localparam int DEN_W   = SUM_W;
  localparam int SCORE_W = 16;
  localparam int QUO_W   = SCORE_W + 1;
  localparam int NUM_W   = SUM_W + QUO_W + 1;
  localparam int STEP_W  = $clog2(QUO_W);

  // Job queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FIRST    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  // One finished frame awaiting scoring
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] len;
    status_e          status;
  } job_t;

endpackage

`default_nettype wire

// ===== design/fdms_front.sv =====
// Front end: accepts pixels, owns the two-bank frame store, accumulates the
// absolute differences and classifies each frame end. Depends on fdms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdms_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [fdms_pkg::PIX_W-1:0] pixel_i,
  input  wire logic                     frame_end_i,
  input  wire logic [fdms_pkg::QCNT_W-1:0] fifo_count_i,
  output logic                          job_valid_o,
  output fdms_pkg::job_t                job_o
);
  import fdms_pkg::*;

  logic [PIX_W-1:0] mem [MEM_DEPTH];
  logic [PIX_W-1:0] rd_q;

  logic             ref_valid_q, ref_bank_q;
  logic [CNT_W-1:0] ref_len_q;
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q;
  logic [SUM_W-1:0] sum_q;

  logic             s1_valid_q, s1_use_q, s1_last_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [CNT_W-1:0] s1_len_q;
  status_e          s1_status_q;

  logic             accept, in_range, wbank, ovf_now, use_ref;
  logic [CNT_W-1:0] len_now;
  status_e          status_now;
  logic [ADDR_W:0]  waddr, raddr;
  logic [PIX_W-1:0] diff;
  logic [SUM_W-1:0] sum_next;
  logic [QCNT_W:0]  occupancy;

  // Reserve queue room for a frame end still in the difference stage
  assign occupancy = {1'b0, fifo_count_i} + {{QCNT_W{1'b0}}, (s1_valid_q & s1_last_q)};
  assign full      = (occupancy >= (QCNT_W + 1)'(QDEPTH));
  assign accept    = push & ~full;

  assign in_range = (cnt_q < CNT_W'(MAX_FRAME_PIXELS));
  assign wbank    = ~ref_bank_q;
  assign waddr    = {wbank, cnt_q[ADDR_W-1:0]};
  assign raddr    = {ref_bank_q, cnt_q[ADDR_W-1:0]};
  assign use_ref  = in_range & ref_valid_q & (cnt_q < ref_len_q);
  assign len_now  = in_range ? cnt_q + CNT_W'(1) : cnt_q;
  assign ovf_now  = ovf_q | ~in_range;

  // Classify the frame at its last pixel
  always_comb begin
    if (ovf_now) begin
      status_now = ST_TOO_LONG;
    end else if (!ref_valid_q) begin
      status_now = ST_FIRST;
    end else if (len_now != ref_len_q) begin
      status_now = ST_MISMATCH;
    end else begin
      status_now = ST_OK;
    end
  end

  // Store the pixel in the free bank, read the reference pixel
  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      mem[waddr] <= pixel_i;
    end
    if (accept) begin
      rd_q <= mem[raddr];
    end
  end

  // Per-frame counters and reference state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_valid_q <= 1'b0;
      ref_bank_q  <= 1'b0;
      ref_len_q   <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
    end else if (accept) begin
      if (frame_end_i) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
        if (status_now == ST_FIRST) begin
          ref_valid_q <= 1'b1;
          ref_bank_q  <= wbank;
          ref_len_q   <= len_now;
        end else if (status_now == ST_OK) begin
          ref_bank_q  <= wbank;
        end
      end else begin
        ovf_q <= ovf_now;
        if (in_range) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  // Difference stage, registered in the cycle after acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_use_q    <= 1'b0;
      s1_last_q   <= 1'b0;
      s1_px_q     <= '0;
      s1_len_q    <= '0;
      s1_status_q <= ST_OK;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        s1_use_q    <= use_ref;
        s1_last_q   <= frame_end_i;
        s1_px_q     <= pixel_i;
        s1_len_q    <= len_now;
        s1_status_q <= status_now;
      end
    end
  end

  assign diff     = (s1_px_q > rd_q) ? s1_px_q - rd_q : rd_q - s1_px_q;
  assign sum_next = sum_q + (s1_use_q ? SUM_W'(diff) : '0);

  // Accumulate, and hand the frame total over at frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_valid_q) begin
      sum_q <= s1_last_q ? '0 : sum_next;
    end
  end

  assign job_valid_o = s1_valid_q & s1_last_q;
  assign job_o.sum    = sum_next;
  assign job_o.len    = s1_len_q;
  assign job_o.status = s1_status_q;

endmodule

`default_nettype wire

// ===== design/fdms_job_fifo.sv =====
// Short queue of finished frames between the front and back ends.
// Depends on fdms_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module fdms_job_fifo (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_i,
  input  wire fdms_pkg::job_t              wr_data_i,
  input  wire logic                        rd_i,
  output fdms_pkg::job_t                   rd_data_o,
  output logic                             not_empty_o,
  output logic [fdms_pkg::QCNT_W-1:0]      count_o
);
  import fdms_pkg::*;

  job_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_wr, do_rd;

  // Writes are kept within room by the front end's full flag
  assign do_wr = wr_i;
  assign do_rd = rd_i & (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (do_rd) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign rd_data_o   = slot_q[rptr_q];
  assign not_empty_o = (count_q != '0);
  assign count_o     = count_q;

endmodule

`default_nettype wire

// ===== design/fdms_back.sv =====
// Back end: scores each finished frame with a bit-serial restoring divider
// and holds the result for the output side. Depends on fdms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdms_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          job_avail_i,
  input  wire fdms_pkg::job_t                job_i,
  output logic                               job_take_o,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [fdms_pkg::SCORE_W-1:0]       score_o,
  output logic [1:0]                         status_o
);
  import fdms_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_PREP,
    B_DIV,
    B_DONE
  } bstate_e;

  bstate_e            state_q;
  logic [SUM_W-1:0]   sum_q;
  logic [DEN_W-1:0]   den_q;
  status_e            jstat_q;
  logic [DEN_W:0]     rem_q;
  logic [QUO_W-1:0]   quo_q;
  logic [STEP_W-1:0]  step_q;
  logic               out_valid_q;
  logic [SCORE_W-1:0] score_q;
  status_e            ostat_q;

  logic [NUM_W-1:0]   num;
  logic [DEN_W+1:0]   trial, divisor;
  logic               ge;
  logic [SCORE_W-1:0] score_fin;
  logic               out_free;
  logic               out_load;

  // Numerator sum*2^17 + den gives round-half-up of sum*2^16/den
  assign num     = {1'b0, sum_q, {QUO_W{1'b0}}} + NUM_W'(den_q);
  assign trial   = {rem_q, quo_q[QUO_W-1]};
  assign divisor = {1'b0, den_q, 1'b0};
  assign ge      = (trial >= divisor);

  assign score_fin  = quo_q[QUO_W-1] ? {SCORE_W{1'b1}} : quo_q[SCORE_W-1:0];
  assign out_free   = ~out_valid_q | pop;
  assign out_load   = (state_q == B_DONE) & out_free;
  assign job_take_o = (state_q == B_IDLE) & job_avail_i;

  // Sequence one job at a time; hold the result until popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      sum_q       <= '0;
      den_q       <= '0;
      jstat_q     <= ST_OK;
      rem_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      score_q     <= '0;
      ostat_q     <= ST_OK;
    end else begin
      // Raise the result when loaded, drop it once popped
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (job_avail_i) begin
            sum_q   <= job_i.sum;
            den_q   <= DEN_W'({job_i.len, 8'd0} - {8'd0, job_i.len});
            jstat_q <= job_i.status;
            state_q <= (job_i.status == ST_OK) ? B_PREP : B_DONE;
          end
        end
        B_PREP: begin
          rem_q   <= num[NUM_W-1:QUO_W];
          quo_q   <= num[QUO_W-1:0];
          step_q  <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          rem_q  <= ge ? (DEN_W+1)'(trial - divisor) : trial[DEN_W:0];
          quo_q  <= {quo_q[QUO_W-2:0], ge};
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(QUO_W - 1)) begin
            state_q <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            score_q <= (jstat_q == ST_OK) ? score_fin : '0;
            ostat_q <= jstat_q;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign empty    = ~out_valid_q;
  assign score_o  = score_q;
  assign status_o = ostat_q;

endmodule

`default_nettype wire

// ===== design/frame_difference_motion_score.sv =====
// Frame difference motion score: pixels come in one per push; frame_end_i
// marks the last pixel of a frame, and each frame end yields one result
// transaction with a Q0.16 score of sum|cur - ref| / (length*255) and a
// status (ok, first frame, length mismatch, frame too long). Pixels are
// taken at one per cycle while full is low; the two-bank frame store has
// one write and one read port, used once each per pixel. An ok frame end
// takes the back end through job take, set-up, 17 quotient bits in the
// bit-serial divider and hand-off; other statuses go from job take straight
// to hand-off. Up to four finished frames queue ahead of it, after which
// full stays high until the back end takes one. The score shows 0 for any
// status other than ok. The frame store needs no clearing after reset.
// Depends on fdms_pkg, fdms_front, fdms_job_fifo and fdms_back.
`timescale 1ns / 1ps
`default_nettype none

module frame_difference_motion_score (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [fdms_pkg::PIX_W-1:0]    pixel_i,
  input  wire logic                          frame_end_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [fdms_pkg::SCORE_W-1:0]       score_o,
  output logic [1:0]                         status_o
);
  import fdms_pkg::*;

  logic              job_valid, job_avail, job_take;
  job_t              job_wr, job_rd;
  logic [QCNT_W-1:0] fifo_count;

  fdms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .pixel_i      (pixel_i),
    .frame_end_i  (frame_end_i),
    .fifo_count_i (fifo_count),
    .job_valid_o  (job_valid),
    .job_o        (job_wr)
  );

  fdms_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (job_valid),
    .wr_data_i   (job_wr),
    .rd_i        (job_take),
    .rd_data_o   (job_rd),
    .not_empty_o (job_avail),
    .count_o     (fifo_count)
  );

  fdms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (job_avail),
    .job_i       (job_rd),
    .job_take_o  (job_take),
    .empty       (empty),
    .pop         (pop),
    .score_o     (score_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for frame_difference_motion_score: drives pixel frames through
// the push/full queue side and scores every result transaction against its own prediction.
// Depends on fdms_pkg and the frame_difference_motion_score top level.
`timescale 1ns / 1ps

// One expected result transaction
typedef struct packed {
  logic [15:0]        score;
  fdms_pkg::status_e  status;
} frame_result_t;

// Predicts the score and status of every frame and checks the results in order
class result_scoreboard;
  bit [7:0]        frame_mem [2][fdms_pkg::MAX_FRAME_PIXELS];
  bit              ref_bank;
  bit              ref_valid;
  int unsigned     ref_len;
  int unsigned     pix_count;
  int unsigned     sad;
  bit              too_long;
  frame_result_t   expected_q[$];
  int unsigned     errors;
  int unsigned     pixels_in;
  int unsigned     status_seen [4];

  // Note one accepted pixel; queue a result at frame end
  function void note_pixel(bit [7:0] px, bit last);
    bit              wr_bank;
    bit [7:0]        ref_px;
    longint unsigned den;
    longint unsigned quo;
    frame_result_t   res;
    wr_bank = ~ref_bank;
    pixels_in++;
    if (pix_count < fdms_pkg::MAX_FRAME_PIXELS) begin
      frame_mem[wr_bank][pix_count] = px;
      if (ref_valid && pix_count < ref_len) begin
        ref_px = frame_mem[ref_bank][pix_count];
        sad += (px > ref_px) ? px - ref_px : ref_px - px;
      end
      pix_count++;
    end else begin
      too_long = 1'b1;
    end
    if (!last) return;

    res.score = '0;
    if (too_long) begin
      res.status = fdms_pkg::ST_TOO_LONG;
    end else if (!ref_valid) begin
      res.status = fdms_pkg::ST_FIRST;
      ref_valid  = 1'b1;
      ref_bank   = wr_bank;
      ref_len    = pix_count;
    end else if (pix_count != ref_len) begin
      res.status = fdms_pkg::ST_MISMATCH;
    end else begin
      // Round half up, saturate a full difference to the top code
      res.status = fdms_pkg::ST_OK;
      den = pix_count;
      den = den * 255;
      quo = sad;
      quo = (quo * 131072 + den) / (2 * den);
      res.score = (quo > 65535) ? 16'hFFFF : quo[15:0];
      ref_bank = wr_bank;
    end
    expected_q.push_back(res);
    pix_count = 0;
    sad       = 0;
    too_long  = 1'b0;
  endfunction

  // Compare one accepted result transaction with the oldest expectation
  function void check_result(logic [15:0] score, logic [1:0] status);
    frame_result_t exp_res;
    if (expected_q.size() == 0) begin
      $error("unexpected result: score %0d status %0d", score, status);
      errors++;
      return;
    end
    exp_res = expected_q.pop_front();
    status_seen[exp_res.status]++;
    if (status !== exp_res.status) begin
      $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
      errors++;
    end
    if (score !== exp_res.score) begin
      $error("score mismatch: expected %0d, actual %0d", exp_res.score, score);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  import fdms_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 120;

  typedef enum {PIX_RANDOM, PIX_ALT_LOW, PIX_ALT_HIGH, PIX_EXTREME, PIX_MID} pix_mode_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [PIX_W-1:0]   pixel = '0;
  logic               frame_end = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [SCORE_W-1:0] result_score;
  logic [1:0]         status;

  logic               calm = 1'b0;
  logic               hold_req = 1'b0;
  logic               hold_done = 1'b0;
  int unsigned        hold_left = 0;
  int unsigned        cycles = 0;

  result_scoreboard   sb;

  frame_difference_motion_score dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .pixel_i     (pixel),
    .frame_end_i (frame_end),
    .empty       (empty),
    .pop         (pop),
    .score_o     (result_score),
    .status_o    (status)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check each popped transaction, then pick the next pop level
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(result_score, status);
      if (hold_left != 0) begin
        pop       <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        pop       <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (calm) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 23);
      end
    end
  end

  // Offer one pixel, hold until taken, then idle now and then
  task automatic offer_pixel(input logic [7:0] px, input logic last);
    push      <= 1'b1;
    pixel     <= px;
    frame_end <= last;
    do @(posedge clk); while (full);
    sb.note_pixel(px, last);
    if (!calm && $urandom_range(99) < 23) begin
      push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Send a whole frame of the given length and pixel pattern
  task automatic send_frame(input int unsigned len, input pix_mode_e mode);
    logic [7:0] px;
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        PIX_ALT_LOW:  px = i[0] ? 8'hFF : 8'h00;
        PIX_ALT_HIGH: px = i[0] ? 8'h00 : 8'hFF;
        PIX_EXTREME:  px = $urandom_range(1) ? 8'hFF : 8'h00;
        PIX_MID:      px = 8'd125 + 8'($urandom_range(6));
        default:      px = 8'($urandom);
      endcase
      offer_pixel(px, i == len - 1);
    end
  endtask

  initial begin
    int unsigned ref_len;
    int unsigned rnd_items;
    int unsigned len;
    bit          long_done;
    bit          drained;
    pix_mode_e   mode;
    sb        = new();
    rnd_items = 0;
    long_done = 1'b0;
    drained   = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: too-long first frame, reference, full and zero difference, wrong lengths
    ref_len = $urandom_range(4, 2);
    send_frame(MAX_FRAME_PIXELS + 1, PIX_RANDOM);
    send_frame(ref_len, PIX_ALT_LOW);
    send_frame(ref_len, PIX_ALT_HIGH);
    send_frame(ref_len, PIX_ALT_HIGH);
    send_frame(ref_len - 1, PIX_EXTREME);
    send_frame(ref_len + 1, PIX_RANDOM);
    send_frame(1, PIX_RANDOM);

    // Random: mostly matching frames, some wrong lengths, one oversize frame
    while (rnd_items < RANDOM_ITEMS) begin
      if (!long_done && rnd_items >= 340) begin
        send_frame(MAX_FRAME_PIXELS + $urandom_range(3, 1), PIX_RANDOM);
        long_done = 1'b1;
      end
      if ($urandom_range(99) < 70) len = ref_len;
      else len = $urandom_range(2 * ref_len + 2, 1);
      if ($urandom_range(1)) mode = PIX_RANDOM;
      else mode = pix_mode_e'($urandom_range(4));
      send_frame(len, mode);
      rnd_items += len;

      if (rnd_items >= 150) hold_req <= 1'b1;
      calm <= (rnd_items >= 220 && rnd_items < 320);
      if (!drained && rnd_items >= 460) begin
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        drained = 1'b1;
      end
    end

    // Let the last results arrive, then settle
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d pixels over %0d frames in %0d cycles, reference length %0d.",
             sb.pixels_in, sb.status_seen[0] + sb.status_seen[1] + sb.status_seen[2]
             + sb.status_seen[3], cycles, ref_len);
    $display("Frames scored: %0d ok, %0d first, %0d length mismatch, %0d oversize.",
             sb.status_seen[ST_OK], sb.status_seen[ST_FIRST],
             sb.status_seen[ST_MISMATCH], sb.status_seen[ST_TOO_LONG]);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
